/* hw/rtl/ptc_pkg.sv */
package ptc_pkg;

	localparam int unsigned ID_W   = 11;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PCT_W  = 7;
	localparam int unsigned NUM_W  = 16;
	localparam int unsigned CNT_W  = 3;
	localparam int unsigned CIDX_W = 3;

	localparam logic [BYTE_W-1:0] PCT_SCALE         = 8'd100;
	localparam logic [BYTE_W-1:0] TORQUE_FULL_SCALE = 8'd100;

	localparam logic [ID_W-1:0] ID_BUTTON = 11'd0;
	localparam logic [ID_W-1:0] ID_THR1   = 11'd1;
	localparam logic [ID_W-1:0] ID_THR2   = 11'd2;
	localparam logic [ID_W-1:0] ID_BRAKE  = 11'd3;

	localparam logic [CIDX_W-1:0] REG_THR1_LOW  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_THR1_HIGH = 3'd1;
	localparam logic [CIDX_W-1:0] REG_THR2_LOW  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_THR2_HIGH = 3'd3;
	localparam logic [CIDX_W-1:0] REG_BRAKE_LIM = 3'd4;
	localparam logic [CIDX_W-1:0] REG_TQ_FLOOR  = 3'd5;

	localparam logic [1:0] CMD_DISABLE = 2'd0;
	localparam logic [1:0] CMD_ENABLE  = 2'd1;
	localparam logic [1:0] CMD_TORQUE  = 2'd2;

	typedef struct packed {
		logic              frame_valid;
		logic [ID_W-1:0]   frame_id;
		logic [BYTE_W-1:0] data_byte;
	} ptc_in_t;

	typedef struct packed {
		logic [1:0]        command_state;
		logic [BYTE_W-1:0] torque_low;
		logic [BYTE_W-1:0] torque_high;
		logic              inverter_enable;
	} ptc_out_t;

	typedef enum logic [1:0] {
		OP_A,
		OP_B,
		OP_T
	} div_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic    take;
		logic    div_start;
		div_op_t div_op;
		logic    cap;
		logic    emit;
	} ptc_cmd_t;

	typedef struct packed {
		logic both_fresh;
		logic div_done;
		logic out_free;
	} ptc_stat_t;

endpackage

/* hw/rtl/ptc_div.sv */
module ptc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ptc_pkg::NUM_W-1:0]  dividend,
	input  logic [ptc_pkg::BYTE_W-1:0] divisor,
	output logic                      done,
	output logic [ptc_pkg::NUM_W-1:0]  quotient
);
	import ptc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] rem_q;
	logic [BYTE_W-1:0] den_q;
	logic [NUM_W-1:0]  quo_q;

	logic [BYTE_W:0]   r1, r2;
	logic              ge1, ge2;
	logic [BYTE_W-1:0] n1, n2;
	logic [NUM_W-1:0]  q1, q2;

	// two restoring steps per cycle
	always_comb begin
		r1  = {rem_q, quo_q[NUM_W-1]};
		ge1 = r1 >= {1'b0, den_q};
		n1  = ge1 ? BYTE_W'(r1 - {1'b0, den_q}) : r1[BYTE_W-1:0];
		q1  = {quo_q[NUM_W-2:0], ge1};
		r2  = {n1, q1[NUM_W-1]};
		ge2 = r2 >= {1'b0, den_q};
		n2  = ge2 ? BYTE_W'(r2 - {1'b0, den_q}) : r2[BYTE_W-1:0];
		q2  = {q1[NUM_W-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= n2;
			quo_q <= q2;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/ptc_dp.sv */
module ptc_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [ptc_pkg::CIDX_W-1:0] cfg_index,
	input  logic [ptc_pkg::BYTE_W-1:0] cfg_data,
	input  logic                       in_valid,
	input  ptc_pkg::ptc_in_t           in_data,
	input  logic                       out_ready,
	output logic                       out_valid,
	output ptc_pkg::ptc_out_t          out_data,
	input  ptc_pkg::ptc_cmd_t          cmd,
	output ptc_pkg::ptc_stat_t         stat
);
	import ptc_pkg::*;

	// avg * 100 / TORQUE_FULL_SCALE by reciprocal multiply, exact for products below 2^14
	localparam int unsigned TQ_SHIFT  = 22;
	localparam int unsigned TQ_MUL_W  = 31;
	localparam int unsigned TQ_PROD_W = BYTE_W + TQ_MUL_W;
	localparam logic [TQ_MUL_W-1:0] TQ_MUL = TQ_MUL_W'(((2 ** TQ_SHIFT + TORQUE_FULL_SCALE - 1)
		/ TORQUE_FULL_SCALE) * PCT_SCALE);

	logic [BYTE_W-1:0] thr1_low_q, thr1_high_q, thr2_low_q, thr2_high_q, brake_lim_q;
	logic [PCT_W-1:0]  floor_q;

	logic [BYTE_W-1:0] thr1_q, thr2_q, brake_q;
	logic              fresh1_q, fresh2_q, button_q;
	logic [PCT_W-1:0]  torque_q, pct_a_q, pct_b_q;

	logic              out_valid_q;
	ptc_out_t          out_q;

	logic [BYTE_W-1:0]    sel_v, sel_lo, sel_hi, vc, diff;
	logic [BYTE_W-1:0]    avg_sum;
	logic [PCT_W-1:0]     avg;
	logic [BYTE_W-1:0]    avg_c;
	logic [TQ_PROD_W-1:0] tq_prod;
	logic [PCT_W-1:0]     tq_new;
	logic [NUM_W-1:0]     num;
	logic                 empty_rng;
	logic                 div_done;
	logic [NUM_W-1:0]     quot;
	logic [PCT_W-1:0]     pct;
	ptc_out_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr1_low_q  <= 8'd0;
			thr1_high_q <= 8'd160;
			thr2_low_q  <= 8'd0;
			thr2_high_q <= 8'd70;
			brake_lim_q <= 8'd100;
			floor_q     <= 7'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THR1_LOW:  thr1_low_q  <= cfg_data;
				REG_THR1_HIGH: thr1_high_q <= cfg_data;
				REG_THR2_LOW:  thr2_low_q  <= cfg_data;
				REG_THR2_HIGH: thr2_high_q <= cfg_data;
				REG_BRAKE_LIM: brake_lim_q <= cfg_data;
				REG_TQ_FLOOR:  floor_q     <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// torque average and scaling, and operand select, clamp and scale for the selected division
	always_comb begin
		avg_sum = {1'b0, pct_a_q} + {1'b0, pct_b_q};
		avg     = avg_sum[BYTE_W-1:1];
		avg_c   = ({1'b0, avg} > TORQUE_FULL_SCALE) ? TORQUE_FULL_SCALE : {1'b0, avg};
		tq_prod = TQ_PROD_W'(avg_c) * TQ_PROD_W'(TQ_MUL);
		tq_new  = tq_prod[TQ_SHIFT +: PCT_W];
		case (cmd.div_op)
			OP_A: begin
				sel_v  = thr1_q;
				sel_lo = thr1_low_q;
				sel_hi = thr1_high_q;
			end
			OP_B: begin
				sel_v  = thr2_q;
				sel_lo = thr2_low_q;
				sel_hi = thr2_high_q;
			end
			default: begin
				sel_v  = '0;
				sel_lo = '0;
				sel_hi = '0;
			end
		endcase
		empty_rng = sel_hi <= sel_lo;
		if (sel_v < sel_lo)
			vc = sel_lo;
		else if (sel_v > sel_hi)
			vc = sel_hi;
		else
			vc = sel_v;
		diff = vc - sel_lo;
		num  = NUM_W'(diff) * NUM_W'(PCT_SCALE);
		pct  = empty_rng ? '0 : quot[PCT_W-1:0];
	end

	ptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num),
		.divisor  (BYTE_W'(sel_hi - sel_lo)),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr1_q   <= '0;
			thr2_q   <= '0;
			brake_q  <= '0;
			fresh1_q <= 1'b0;
			fresh2_q <= 1'b0;
			button_q <= 1'b0;
			torque_q <= '0;
		end else begin
			if (cmd.take && in_valid && in_data.frame_valid) begin
				case (in_data.frame_id)
					ID_BUTTON: button_q <= in_data.data_byte != '0;
					ID_THR1: begin
						thr1_q   <= in_data.data_byte;
						fresh1_q <= 1'b1;
					end
					ID_THR2: begin
						thr2_q   <= in_data.data_byte;
						fresh2_q <= 1'b1;
					end
					ID_BRAKE: brake_q <= in_data.data_byte;
					default: ;
				endcase
			end
			if (cmd.cap && cmd.div_op == OP_T) begin
				torque_q <= tq_new;
				fresh1_q <= 1'b0;
				fresh2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap && cmd.div_op == OP_A)
			pct_a_q <= pct;
		if (cmd.cap && cmd.div_op == OP_B)
			pct_b_q <= pct;
	end

	always_comb begin
		if (brake_q >= brake_lim_q)
			res.command_state = CMD_DISABLE;
		else if (button_q)
			res.command_state = CMD_TORQUE;
		else if (torque_q <= floor_q)
			res.command_state = CMD_ENABLE;
		else
			res.command_state = CMD_DISABLE;
		res.torque_low      = (res.command_state == CMD_TORQUE) ? {1'b0, torque_q} : '0;
		res.torque_high     = '0;
		res.inverter_enable = res.command_state != CMD_DISABLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign stat.both_fresh = fresh1_q && fresh2_q;
	assign stat.div_done   = div_done;
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

/* hw/rtl/ptc_ctrl.sv */
module ptc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ptc_pkg::ptc_stat_t stat,
	output ptc_pkg::ptc_cmd_t  cmd
);
	import ptc_pkg::*;

	ctrl_state_t state_q, state_d;
	div_op_t     op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_A;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		cmd.take      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_op    = op_q;
		cmd.cap       = 1'b0;
		cmd.emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (in_valid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.both_fresh) begin
					op_d    = OP_A;
					state_d = ST_START;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_START: begin
				// torque scaling needs no divider pass
				if (op_q == OP_T) begin
					cmd.cap = 1'b1;
					state_d = ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (stat.div_done) begin
					cmd.cap = 1'b1;
					case (op_q)
						OP_A: begin
							op_d    = OP_B;
							state_d = ST_START;
						end
						OP_B: begin
							op_d    = OP_T;
							state_d = ST_START;
						end
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/pedal_to_torque_command.sv */
// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[7:0]
// in        in         in_valid / in_ready    ptc_in_t  (frame_valid, frame_id, data_byte)
// out       out        out_valid / out_ready  ptc_out_t (command_state, torque bytes, enable)
//
// A poll that completes no throttle pair passes ST_IDLE, ST_CHECK and ST_EMIT; the result is registered.
// A poll that completes both throttles runs two divisions on one 2-bit-per-cycle divider
// (start, busy and done phases each) and one torque scaling step in ST_START before ST_EMIT.
// Reset loads the register defaults and clears all readings and fresh marks.
// The output register holds one result; a new poll is taken while it waits.
// cfg_ready is always high.
module pedal_to_torque_command (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ptc_pkg::CIDX_W-1:0] cfg_index,
	input  logic [ptc_pkg::BYTE_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ptc_pkg::ptc_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ptc_pkg::ptc_out_t          out_data
);
	import ptc_pkg::*;

	ptc_cmd_t  cmd;
	ptc_stat_t stat;

	assign cfg_ready = 1'b1;
	assign in_ready  = cmd.take;

	ptc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result written over a pending one");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !cmd.emit |=> !out_valid)
		else $error("result repeated after transfer");

	a_div_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !stat.div_done)
		else $error("divider done right after start");

endmodule
